/* design/rrts_pkg.sv */
// shared types, codes and defaults for the round-robin thread slot scheduler
package rrts_pkg;

   localparam int SLOTS_DEF       = 4;
   localparam int STACK_BYTES_DEF = 8192;

   localparam int ADDR_W = 64;
   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;
   localparam int SLOT_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_YIELD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EXIT   = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NONE     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_FUNC = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

/* design/rrts_ram.sv */
// generic single write, single read ram with registered read data
module rrts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/round_robin_thread_slot_scheduler.sv */
// round-robin cooperative thread slot scheduler top level
//
//   channel   direction  handshake              beat
//   req_      in         req_valid / req_stall  func, entry_address
//   rsp_      out        rsp_valid / rsp_stall  status, slots, switched, entry, stack top
//   csr_      in         csr_valid / csr_ready  stack_region_base
//
// one slot is examined per cycle by a single compare and a shared 64-bit adder.
// create: scans up from slot 0 and stops at the lowest free slot, or reports full at the last slot.
// yield/exit: steps from the slot after the running one to the first runnable one,
// then reads its entry from the ram, or reports none. bad operation: next cycle.
// reset leaves slot 0 running and the others free; req_stall stays high from
// acceptance until the result beat leaves, and the result holds while rsp_stall is high.
module round_robin_thread_slot_scheduler #(
   parameter int SLOTS       = rrts_pkg::SLOTS_DEF,
   parameter int STACK_BYTES = rrts_pkg::STACK_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rrts_pkg::ADDR_W-1:0] csr_data,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [rrts_pkg::FUNC_W-1:0] req_func,
   input  logic [rrts_pkg::ADDR_W-1:0] req_entry_address,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rrts_pkg::STAT_W-1:0] rsp_status,
   output logic [rrts_pkg::SLOT_W-1:0] rsp_slot,
   output logic [rrts_pkg::SLOT_W-1:0] rsp_previous_slot,
   output logic                        rsp_switched,
   output logic [rrts_pkg::ADDR_W-1:0] rsp_slot_entry_address,
   output logic [rrts_pkg::ADDR_W-1:0] rsp_stack_top
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [rrts_pkg::ADDR_W-1:0] STACK_INC = rrts_pkg::ADDR_W'(STACK_BYTES);

   rrts_pkg::state_type state_ff, state_in;

   logic [SLOTS-1:0]            busy_ff, busy_in;
   logic [SLOTS-1:0]            ready_ff, ready_in;
   logic [IDX_W-1:0]            running_ff, running_in;
   logic [rrts_pkg::ADDR_W-1:0] base_ff;
   logic [rrts_pkg::FUNC_W-1:0] op_ff, op_in;
   logic [rrts_pkg::ADDR_W-1:0] entry_ff, entry_in;
   logic [IDX_W-1:0]            ptr_ff, ptr_in;
   logic [IDX_W-1:0]            prev_ff, prev_in;
   logic [IDX_W-1:0]            slot_ff, slot_in;
   logic [rrts_pkg::STAT_W-1:0] status_ff, status_in;
   logic                        switched_ff, switched_in;
   logic [rrts_pkg::ADDR_W-1:0] eaddr_ff, eaddr_in;
   logic [rrts_pkg::ADDR_W-1:0] top_ff, top_in;

   logic                        is_create;
   logic                        free_hit;
   logic                        run_hit;
   logic                        ptr_last;
   logic                        ptr_back;
   logic [IDX_W-1:0]            ptr_next;
   logic [IDX_W-1:0]            running_next;
   logic [rrts_pkg::ADDR_W-1:0] top_step;
   logic [IDX_W+1:0]            slot_wide;
   logic [IDX_W+1:0]            prev_wide;

   logic                        ram_wr_en;
   logic                        ram_rd_en;
   logic [rrts_pkg::ADDR_W-1:0] ram_rd_data;

   assign is_create    = (op_ff == rrts_pkg::FUNC_CREATE);
   assign free_hit     = !busy_ff[ptr_ff];
   assign run_hit      = ready_ff[ptr_ff];
   assign ptr_last     = (ptr_ff == LAST_IDX);
   assign ptr_back     = (ptr_ff == prev_ff);
   assign ptr_next     = ptr_last ? '0 : ptr_ff + 1'b1;
   assign running_next = (running_ff == LAST_IDX) ? '0 : running_ff + 1'b1;
   assign top_step     = top_ff + STACK_INC;

   rrts_ram #(
      .WIDTH (rrts_pkg::ADDR_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (entry_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_func == rrts_pkg::FUNC_CREATE || req_func == rrts_pkg::FUNC_YIELD
                   || req_func == rrts_pkg::FUNC_EXIT) begin
                  state_in = rrts_pkg::ST_SCAN;
               end else begin
                  state_in = rrts_pkg::ST_DONE;
               end
            end
         end
         rrts_pkg::ST_SCAN: begin
            if (is_create) begin
               if (free_hit || ptr_last) begin
                  state_in = rrts_pkg::ST_DONE;
               end
            end else if (run_hit) begin
               state_in = rrts_pkg::ST_READ;
            end else if (ptr_back) begin
               state_in = rrts_pkg::ST_DONE;
            end
         end
         rrts_pkg::ST_READ: begin
            state_in = rrts_pkg::ST_DONE;
         end
         rrts_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = rrts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrts_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      unique case (state_ff)
         rrts_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         rrts_pkg::ST_SCAN: begin
            ram_wr_en = is_create && free_hit;
            ram_rd_en = !is_create && run_hit;
         end
         rrts_pkg::ST_READ: begin
         end
         rrts_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      busy_in     = busy_ff;
      ready_in    = ready_ff;
      running_in  = running_ff;
      op_in       = op_ff;
      entry_in    = entry_ff;
      ptr_in      = ptr_ff;
      prev_in     = prev_ff;
      slot_in     = slot_ff;
      status_in   = status_ff;
      switched_in = switched_ff;
      eaddr_in    = eaddr_ff;
      top_in      = top_ff;
      unique case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_func;
               entry_in    = req_entry_address;
               prev_in     = running_ff;
               slot_in     = running_ff;
               switched_in = 1'b0;
               eaddr_in    = '0;
               top_in      = '0;
               status_in   = rrts_pkg::STAT_OK;
               case (req_func)
                  rrts_pkg::FUNC_CREATE: begin
                     ptr_in = '0;
                     top_in = base_ff;
                  end
                  rrts_pkg::FUNC_YIELD: begin
                     busy_in[running_ff]  = 1'b1;
                     ready_in[running_ff] = 1'b1;
                     ptr_in               = running_next;
                  end
                  rrts_pkg::FUNC_EXIT: begin
                     busy_in[running_ff]  = 1'b0;
                     ready_in[running_ff] = 1'b0;
                     ptr_in               = running_next;
                  end
                  default: begin
                     status_in = rrts_pkg::STAT_BAD_FUNC;
                  end
               endcase
            end
         end
         rrts_pkg::ST_SCAN: begin
            if (is_create) begin
               if (free_hit) begin
                  busy_in[ptr_ff]  = 1'b1;
                  ready_in[ptr_ff] = 1'b1;
                  slot_in          = ptr_ff;
                  eaddr_in         = entry_ff;
                  top_in           = top_step;
               end else if (ptr_last) begin
                  status_in = rrts_pkg::STAT_FULL;
                  slot_in   = '0;
                  top_in    = '0;
               end else begin
                  ptr_in = ptr_next;
                  top_in = top_step;
               end
            end else begin
               if (run_hit) begin
                  busy_in[ptr_ff]  = 1'b1;
                  ready_in[ptr_ff] = 1'b0;
                  running_in       = ptr_ff;
                  slot_in          = ptr_ff;
                  switched_in      = !ptr_back;
               end else if (ptr_back) begin
                  status_in = rrts_pkg::STAT_NONE;
               end else begin
                  ptr_in = ptr_next;
               end
            end
         end
         rrts_pkg::ST_READ: begin
            eaddr_in = ram_rd_data;
         end
         rrts_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rrts_pkg::ST_IDLE;
         busy_ff    <= SLOTS'(1);
         ready_ff   <= '0;
         running_ff <= '0;
         base_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         busy_ff    <= busy_in;
         ready_ff   <= ready_in;
         running_ff <= running_in;
         if (csr_valid) begin
            base_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      entry_ff    <= entry_in;
      ptr_ff      <= ptr_in;
      prev_ff     <= prev_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      switched_ff <= switched_in;
      eaddr_ff    <= eaddr_in;
      top_ff      <= top_in;
   end

   // slot numbers leave masked to the port width
   assign slot_wide = {2'b00, slot_ff};
   assign prev_wide = {2'b00, prev_ff};

   assign csr_ready              = 1'b1;
   assign rsp_status             = status_ff;
   assign rsp_slot               = slot_wide[rrts_pkg::SLOT_W-1:0];
   assign rsp_previous_slot      = prev_wide[rrts_pkg::SLOT_W-1:0];
   assign rsp_switched           = switched_ff;
   assign rsp_slot_entry_address = eaddr_ff;
   assign rsp_stack_top          = top_ff;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the round-robin thread slot scheduler
module tb_top;

   localparam int SLOTS          = rrts_pkg::SLOTS_DEF;
   localparam int STACK_BYTES    = rrts_pkg::STACK_BYTES_DEF;
   localparam int IDLE_PCT       = 7;
   localparam int SETTLE_CYCLES  = SLOTS + 6;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [rrts_pkg::FUNC_W-1:0] FUNC_INVALID = 2'd3;

   typedef enum logic [1:0] {
      SLOT_FREE,
      SLOT_RUNNING,
      SLOT_RUNNABLE
   } slot_state_type;

   typedef struct {
      logic [rrts_pkg::STAT_W-1:0] status;
      logic [rrts_pkg::SLOT_W-1:0] slot;
      logic [rrts_pkg::SLOT_W-1:0] prev_slot;
      logic                        switched;
      logic [rrts_pkg::ADDR_W-1:0] entry;
      logic [rrts_pkg::ADDR_W-1:0] stack_top;
   } sched_result_type;

   logic                        clock;
   logic                        reset             = 1'b1;
   logic                        csr_valid         = 1'b0;
   logic                        csr_ready;
   logic [rrts_pkg::ADDR_W-1:0] csr_data          = '0;
   logic                        req_valid         = 1'b0;
   logic                        req_stall;
   logic [rrts_pkg::FUNC_W-1:0] req_func          = '0;
   logic [rrts_pkg::ADDR_W-1:0] req_entry_address = '0;
   logic                        rsp_valid;
   logic                        rsp_stall         = 1'b0;
   logic [rrts_pkg::STAT_W-1:0] rsp_status;
   logic [rrts_pkg::SLOT_W-1:0] rsp_slot;
   logic [rrts_pkg::SLOT_W-1:0] rsp_previous_slot;
   logic                        rsp_switched;
   logic [rrts_pkg::ADDR_W-1:0] rsp_slot_entry_address;
   logic [rrts_pkg::ADDR_W-1:0] rsp_stack_top;

   // scheduler copy kept by the testbench
   slot_state_type              slot_state [SLOTS];
   logic [rrts_pkg::ADDR_W-1:0] entries [SLOTS];
   bit                          entry_written [SLOTS];
   int                          cur_slot;
   logic [rrts_pkg::ADDR_W-1:0] stack_base;

   sched_result_type            expected_results [$];
   int                          mismatches  = 0;
   int                          idle_cycles = 0;
   bit                          calm        = 1'b0;

   round_robin_thread_slot_scheduler dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_data               (csr_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_func               (req_func),
      .req_entry_address      (req_entry_address),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_slot               (rsp_slot),
      .rsp_previous_slot      (rsp_previous_slot),
      .rsp_switched           (rsp_switched),
      .rsp_slot_entry_address (rsp_slot_entry_address),
      .rsp_stack_top          (rsp_stack_top)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // round-robin search as yield or exit would see it; -1 when nothing is runnable
   function automatic int find_target(input logic [rrts_pkg::FUNC_W-1:0] f);
      int             k;
      int             s;
      slot_state_type st;
      for (k = 1; k <= SLOTS; k++) begin
         s = (cur_slot + k) % SLOTS;
         if (s == cur_slot)
            st = (f == rrts_pkg::FUNC_YIELD) ? SLOT_RUNNABLE : SLOT_FREE;
         else
            st = slot_state[s];
         if (st == SLOT_RUNNABLE)
            return s;
      end
      return -1;
   endfunction

   function automatic sched_result_type schedule_op(input logic [rrts_pkg::FUNC_W-1:0] f,
                                                    input logic [rrts_pkg::ADDR_W-1:0] addr);
      sched_result_type r;
      int               s;
      int               i;
      r.status    = rrts_pkg::STAT_OK;
      r.slot      = cur_slot[rrts_pkg::SLOT_W-1:0];
      r.prev_slot = cur_slot[rrts_pkg::SLOT_W-1:0];
      r.switched  = 1'b0;
      r.entry     = '0;
      r.stack_top = '0;
      case (f) inside
         rrts_pkg::FUNC_CREATE: begin
            s = -1;
            for (i = SLOTS - 1; i >= 0; i--)
               if (slot_state[i] == SLOT_FREE)
                  s = i;
            if (s < 0) begin
               r.status = rrts_pkg::STAT_FULL;
               r.slot   = '0;
            end else begin
               slot_state[s]    = SLOT_RUNNABLE;
               entries[s]       = addr;
               entry_written[s] = 1'b1;
               r.slot           = s[rrts_pkg::SLOT_W-1:0];
               r.entry          = addr;
               r.stack_top      = stack_base + 64'(s + 1) * 64'(STACK_BYTES);
            end
         end
         rrts_pkg::FUNC_YIELD, rrts_pkg::FUNC_EXIT: begin
            s = find_target(f);
            slot_state[cur_slot] = (f == rrts_pkg::FUNC_YIELD) ? SLOT_RUNNABLE : SLOT_FREE;
            if (s < 0) begin
               r.status = rrts_pkg::STAT_NONE;
            end else begin
               slot_state[s] = SLOT_RUNNING;
               r.switched    = (s != cur_slot);
               cur_slot      = s;
               r.slot        = s[rrts_pkg::SLOT_W-1:0];
               r.entry       = entries[s];
            end
         end
         default: begin
            r.status = rrts_pkg::STAT_BAD_FUNC;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < 100)
         $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [rrts_pkg::ADDR_W-1:0] got,
                              input logic [rrts_pkg::ADDR_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   task automatic send_op(input logic [rrts_pkg::FUNC_W-1:0] f,
                          input logic [rrts_pkg::ADDR_W-1:0] addr);
      int target;
      // never switch to a slot whose entry was never recorded
      if (f == rrts_pkg::FUNC_YIELD || f == rrts_pkg::FUNC_EXIT) begin
         target = find_target(f);
         if (target >= 0 && !entry_written[target])
            f = rrts_pkg::FUNC_CREATE;
      end
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid         <= 1'b1;
      req_func          <= f;
      req_entry_address <= addr;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(schedule_op(f, addr));
   endtask

   task automatic send_random_op();
      int                          pick;
      logic [rrts_pkg::FUNC_W-1:0] f;
      logic [rrts_pkg::ADDR_W-1:0] addr;
      pick = $urandom_range(99);
      if (pick < 35)
         f = rrts_pkg::FUNC_CREATE;
      else if (pick < 70)
         f = rrts_pkg::FUNC_YIELD;
      else if (pick < 95)
         f = rrts_pkg::FUNC_EXIT;
      else
         f = FUNC_INVALID;
      case ($urandom_range(15))
         0:       addr = '0;
         1:       addr = '1;
         default: addr = {$urandom, $urandom};
      endcase
      send_op(f, addr);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_stack_base(input logic [rrts_pkg::ADDR_W-1:0] value);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      stack_base  = value;
   endtask

   task automatic test_directed_ops();
      write_stack_base('0);
      send_op(rrts_pkg::FUNC_EXIT, '1);
      send_op(FUNC_INVALID, '0);
      send_op(rrts_pkg::FUNC_CREATE, '0);
      send_op(rrts_pkg::FUNC_CREATE, '1);
      send_op(rrts_pkg::FUNC_CREATE, 64'h0123_4567_89ab_cdef);
      send_op(rrts_pkg::FUNC_CREATE, 64'hfedc_ba98_7654_3210);
      send_op(rrts_pkg::FUNC_CREATE, 64'h5555_5555_5555_5555);
      send_op(rrts_pkg::FUNC_YIELD, '0);
      send_op(rrts_pkg::FUNC_YIELD, '0);
      send_op(rrts_pkg::FUNC_EXIT, '0);
      send_op(rrts_pkg::FUNC_CREATE, 64'haaaa_aaaa_aaaa_aaaa);
      send_op(rrts_pkg::FUNC_EXIT, '0);
      send_op(rrts_pkg::FUNC_EXIT, '0);
      send_op(rrts_pkg::FUNC_EXIT, '0);
      send_op(rrts_pkg::FUNC_EXIT, '0);
      send_op(rrts_pkg::FUNC_YIELD, '0);
      send_op(FUNC_INVALID, '1);
      send_op(rrts_pkg::FUNC_YIELD, '1);
      send_op(rrts_pkg::FUNC_CREATE, {$urandom, $urandom});
      send_op(rrts_pkg::FUNC_YIELD, '0);
      send_op(rrts_pkg::FUNC_EXIT, '0);
   endtask

   // each phase runs with a different stack base, extremes first
   task automatic test_random_mix();
      int                          phase;
      logic [rrts_pkg::ADDR_W-1:0] base;
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0:       base = '1;
            1:       base = 64'hffff_ffff_ffff_e000;
            2:       base = 64'h8000_0000_0000_0000;
            default: base = {$urandom, $urandom};
         endcase
         write_stack_base(base);
         repeat (100) send_random_op();
      end
   endtask

   task automatic test_back_to_back();
      calm = 1'b1;
      write_stack_base({$urandom, $urandom});
      repeat (100) send_random_op();
      wait_results_drained();
      calm = 1'b0;
   endtask

   task automatic test_one_at_a_time();
      repeat (20) begin
         send_random_op();
         wait_results_drained();
      end
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin : check_results
      sched_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            want = expected_results.pop_front();
            check_field("status", 64'(rsp_status), 64'(want.status));
            check_field("slot", 64'(rsp_slot), 64'(want.slot));
            check_field("previous_slot", 64'(rsp_previous_slot), 64'(want.prev_slot));
            check_field("switched", 64'(rsp_switched), 64'(want.switched));
            check_field("slot_entry_address", rsp_slot_entry_address, want.entry);
            check_field("stack_top", rsp_stack_top, want.stack_top);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : main
      int i;
      for (i = 0; i < SLOTS; i++) begin
         slot_state[i]    = SLOT_FREE;
         entries[i]       = '0;
         entry_written[i] = 1'b0;
      end
      slot_state[0] = SLOT_RUNNING;
      cur_slot      = 0;
      stack_base    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_random_mix();
      test_back_to_back();
      test_one_at_a_time();

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
